// ----- src/pdfm_pkg.sv -----
// pdfm_pkg: shared types and constants for the pwm duty and frequency meter
// used by pdfm_ctrl, pdfm_dp and pwm_duty_frequency_meter; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pdfm_pkg;

   localparam int CAPTURE_W   = 16;
   localparam int SCALE_W     = 8;
   localparam int TIME_W      = 16;
   localparam int SUM_W       = TIME_W + 1;
   localparam int DUTY_W      = 7;
   localparam int FREQ_W      = 20;
   localparam int PROD_W      = TIME_W + DUTY_W;
   localparam int DVD_W       = FREQ_W;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 32;
   localparam int RSP_USER_W  = 2;
   localparam int CSR_ADDR_W  = 1;
   localparam int CSR_DATA_W  = 8;

   localparam logic [DUTY_W-1:0]   PERCENT_SCALE      = 7'd100;
   localparam logic [FREQ_W-1:0]   MICROS_PER_SECOND  = 20'd1000000;
   localparam logic [SCALE_W-1:0]  DEFAULT_TICK_SCALE = 8'd4;

   // one quotient bit per step
   localparam int STEP_CNT_W = 5;
   localparam logic [STEP_CNT_W-1:0] DUTY_LAST_STEP = STEP_CNT_W'(DUTY_W - 1);
   localparam logic [STEP_CNT_W-1:0] FREQ_LAST_STEP = STEP_CNT_W'(FREQ_W - 1);

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_START_EDGE_RISING = 1'b0,
      REG_TICK_SCALE        = 1'b1
   } csr_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_LOAD,
      ST_DUTY,
      ST_FLOAD,
      ST_FREQ,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic prep;
      logic start_duty;
      logic start_freq;
      logic step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic period_zero;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// ----- src/pdfm_ctrl.sv -----
// pdfm_ctrl: sequencing state machine for the meter
// depends on pdfm_pkg; drives pdfm_dp through cmd_type and reads status_type
`timescale 1ns / 1ps
`default_nettype none

module pdfm_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire pdfm_pkg::status_type status,
   output pdfm_pkg::cmd_type         cmd
);

   pdfm_pkg::state_type               state_ff, state_in;
   logic [pdfm_pkg::STEP_CNT_W-1:0]   cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pdfm_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         pdfm_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = pdfm_pkg::ST_PREP;
            end
         end
         pdfm_pkg::ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = pdfm_pkg::ST_LOAD;
         end
         pdfm_pkg::ST_LOAD: begin
            cnt_in = '0;
            if (status.period_zero) begin
               state_in = pdfm_pkg::ST_DONE;
            end else begin
               cmd.start_duty = 1'b1;
               state_in       = pdfm_pkg::ST_DUTY;
            end
         end
         pdfm_pkg::ST_DUTY: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == pdfm_pkg::DUTY_LAST_STEP) begin
               state_in = pdfm_pkg::ST_FLOAD;
            end
         end
         pdfm_pkg::ST_FLOAD: begin
            cmd.start_freq = 1'b1;
            cnt_in         = '0;
            state_in       = pdfm_pkg::ST_FREQ;
         end
         pdfm_pkg::ST_FREQ: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == pdfm_pkg::FREQ_LAST_STEP) begin
               state_in = pdfm_pkg::ST_DONE;
            end
         end
         pdfm_pkg::ST_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = pdfm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pdfm_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- src/pdfm_dp.sv -----
// pdfm_dp: edge timing registers, scaling multiplier, shared restoring divider
// and result register; depends on pdfm_pkg, commanded by pdfm_ctrl
`timescale 1ns / 1ps
`default_nettype none

module pdfm_dp (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [pdfm_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [pdfm_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic [pdfm_pkg::RSP_USER_W-1:0]        rsp_tuser,
   input  wire logic                              csr_we,
   input  wire logic [pdfm_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire logic [pdfm_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire pdfm_pkg::cmd_type                 cmd,
   output pdfm_pkg::status_type                   status
);

   logic                                start_edge_ff, start_edge_in;
   logic [pdfm_pkg::SCALE_W-1:0]        tick_ff, tick_in;
   logic                                expect_ff, expect_in;
   logic [pdfm_pkg::CAPTURE_W-1:0]      last_ff, last_in;
   logic [pdfm_pkg::TIME_W-1:0]         high_ff, high_in;
   logic [pdfm_pkg::TIME_W-1:0]         low_ff, low_in;
   logic                                edge_ff, edge_in;
   logic [pdfm_pkg::SUM_W-1:0]          sum_ff, sum_in;
   logic [pdfm_pkg::PROD_W-1:0]         prod_ff, prod_in;
   logic [pdfm_pkg::SUM_W-1:0]          rem_ff, rem_in;
   logic [pdfm_pkg::DVD_W-1:0]          dvd_ff, dvd_in;
   logic [pdfm_pkg::DUTY_W-1:0]         duty_ff, duty_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [pdfm_pkg::DUTY_W-1:0]         rsp_duty_ff, rsp_duty_in;
   logic [pdfm_pkg::FREQ_W-1:0]         rsp_freq_ff, rsp_freq_in;
   logic                                rsp_edge_ff, rsp_edge_in;
   logic                                rsp_zero_ff, rsp_zero_in;

   logic [pdfm_pkg::CAPTURE_W-1:0]            diff;
   logic [pdfm_pkg::TIME_W+pdfm_pkg::SCALE_W-1:0] scaled_full;
   logic [pdfm_pkg::SUM_W:0]                  rem_sh;
   logic [pdfm_pkg::SUM_W:0]                  trial;
   logic                                      qbit;
   logic                                      period_zero;

   assign diff        = req_tdata - last_ff;
   assign scaled_full = diff * tick_ff;
   assign period_zero = (sum_ff == '0);

   // restoring division, one quotient bit per step
   assign rem_sh = {rem_ff, dvd_ff[pdfm_pkg::DVD_W-1]};
   assign trial  = rem_sh - {1'b0, sum_ff};
   assign qbit   = ~trial[pdfm_pkg::SUM_W];

   assign status.period_zero = period_zero;
   assign status.out_free    = ~rsp_valid_ff | rsp_tready;

   always_comb begin
      start_edge_in = start_edge_ff;
      tick_in       = tick_ff;
      expect_in     = expect_ff;
      last_in       = last_ff;
      high_in       = high_ff;
      low_in        = low_ff;
      edge_in       = edge_ff;
      sum_in        = sum_ff;
      prod_in       = prod_ff;
      rem_in        = rem_ff;
      dvd_in        = dvd_ff;
      duty_in       = duty_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_duty_in   = rsp_duty_ff;
      rsp_freq_in   = rsp_freq_ff;
      rsp_edge_in   = rsp_edge_ff;
      rsp_zero_in   = rsp_zero_ff;

      if (csr_we) begin
         unique case (pdfm_pkg::csr_reg_type'(csr_addr))
            pdfm_pkg::REG_START_EDGE_RISING: begin
               start_edge_in = csr_wdata[0];
               expect_in     = csr_wdata[0];
            end
            pdfm_pkg::REG_TICK_SCALE: begin
               tick_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end

      if (cmd.capture) begin
         edge_in   = expect_ff;
         expect_in = ~expect_ff;
         last_in   = req_tdata;
         if (expect_ff) begin
            low_in = scaled_full[pdfm_pkg::TIME_W-1:0];
         end else begin
            high_in = scaled_full[pdfm_pkg::TIME_W-1:0];
         end
      end

      if (cmd.prep) begin
         sum_in  = {1'b0, high_ff} + {1'b0, low_ff};
         prod_in = high_ff * pdfm_pkg::PERCENT_SCALE;
      end

      // duty quotient fits in DUTY_W bits, so the upper dividend bits start as remainder
      if (cmd.start_duty) begin
         rem_in = {1'b0, prod_ff[pdfm_pkg::PROD_W-1:pdfm_pkg::DUTY_W]};
         dvd_in = {prod_ff[pdfm_pkg::DUTY_W-1:0],
                   {(pdfm_pkg::DVD_W-pdfm_pkg::DUTY_W){1'b0}}};
      end

      if (cmd.start_freq) begin
         duty_in = dvd_ff[pdfm_pkg::DUTY_W-1:0];
         rem_in  = '0;
         dvd_in  = pdfm_pkg::MICROS_PER_SECOND;
      end

      if (cmd.step) begin
         rem_in = qbit ? trial[pdfm_pkg::SUM_W-1:0] : rem_sh[pdfm_pkg::SUM_W-1:0];
         dvd_in = {dvd_ff[pdfm_pkg::DVD_W-2:0], qbit};
      end

      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_edge_in  = edge_ff;
         rsp_zero_in  = period_zero;
         rsp_duty_in  = period_zero ? '0 : duty_ff;
         rsp_freq_in  = period_zero ? '0 : dvd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_edge_ff <= 1'b1;
         tick_ff       <= pdfm_pkg::DEFAULT_TICK_SCALE;
         expect_ff     <= 1'b1;
         last_ff       <= '0;
         high_ff       <= '0;
         low_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         start_edge_ff <= start_edge_in;
         tick_ff       <= tick_in;
         expect_ff     <= expect_in;
         last_ff       <= last_in;
         high_ff       <= high_in;
         low_ff        <= low_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      edge_ff     <= edge_in;
      sum_ff      <= sum_in;
      prod_ff     <= prod_in;
      rem_ff      <= rem_in;
      dvd_ff      <= dvd_in;
      duty_ff     <= duty_in;
      rsp_duty_ff <= rsp_duty_in;
      rsp_freq_ff <= rsp_freq_in;
      rsp_edge_ff <= rsp_edge_in;
      rsp_zero_ff <= rsp_zero_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(pdfm_pkg::RSP_DATA_W-pdfm_pkg::FREQ_W-pdfm_pkg::DUTY_W){1'b0}},
                        rsp_freq_ff, rsp_duty_ff};
   assign rsp_tuser  = {rsp_zero_ff, rsp_edge_ff};

   a_zero_clears_results: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_zero_ff |-> rsp_duty_ff == '0 && rsp_freq_ff == '0)
      else $error("zero period result carries nonzero values");

   a_duty_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_duty_ff <= pdfm_pkg::PERCENT_SCALE)
      else $error("duty above full scale");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      cmd.step |=> rem_ff < sum_ff)
      else $error("divider remainder not below divisor");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("result load did not raise valid");

endmodule

`default_nettype wire

// ----- src/pwm_duty_frequency_meter.sv -----
// Measures duty (percent) and frequency (Hz) of a PWM signal from one capture timestamp
// per edge. A new edge is accepted only after the previous item has gone through the
// shared restoring divider (skipped when high plus low time is zero), which produces
// one quotient bit per cycle: 7 steps for the duty, then 20 for the frequency. A finished
// result sits in the output register, so the next edge is taken while it waits.
// Depends on pdfm_pkg, pdfm_ctrl and pdfm_dp.
`timescale 1ns / 1ps
`default_nettype none

module pwm_duty_frequency_meter (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [pdfm_pkg::REQ_DATA_W-1:0]   req_tdata,   // capture_time
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [pdfm_pkg::RSP_DATA_W-1:0]        rsp_tdata,   // duty_percent, frequency_hz
   output logic [pdfm_pkg::RSP_USER_W-1:0]        rsp_tuser,   // edge_rising, period_zero
   input  wire logic                              csr_we,
   input  wire logic [pdfm_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire logic [pdfm_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   pdfm_pkg::cmd_type    cmd;
   pdfm_pkg::status_type status;

   pdfm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pdfm_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

`default_nettype wire
